FILE: sv/fqp_pkg.sv
// fqp_pkg: shared constants and types for the fastq record parser
// character codes, input kinds, line phases, field tags and the result beat; no dependencies
`default_nettype none

package fqp_pkg;

    // characters of interest in the byte stream
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // input kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOI  = 1'b1;

    // line phases (share their codes with the field tags)
    localparam logic [1:0] PH_NAME    = 2'd0;
    localparam logic [1:0] PH_SEQ     = 2'd1;
    localparam logic [1:0] PH_COMMENT = 2'd2;
    localparam logic [1:0] PH_QUAL    = 2'd3;

    // output field tags
    localparam logic [2:0] TAG_NAME    = 3'd0;
    localparam logic [2:0] TAG_SEQ     = 3'd1;
    localparam logic [2:0] TAG_COMMENT = 3'd2;
    localparam logic [2:0] TAG_QUAL    = 3'd3;
    localparam logic [2:0] TAG_END     = 3'd4;

    // one result beat
    typedef struct packed {
        logic [2:0] tag;
        logic [7:0] fbyte;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/fastq_record_parser.sv
// fastq_record_parser: tags each byte of a fastq stream by record field
// depends on fqp_pkg for character codes, phases and tags
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------
//  input   | i_valid | o_ready | i_kind, i_data_byte
//  output  | o_valid | i_ready | o_field_tag, o_field_byte
//
// one byte is accepted per cycle while o_ready is high; its result enters the
// output register on the next cycle if that register is empty or being taken,
// else the skid stage. the rate is set by the output register plus a one-entry
// skid stage: input ready drops only while the skid stage holds a beat.
// synchronous active-low reset returns the phase tracker to the name phase.
// newlines and the plus marker produce no result, and a record-start '@' only
// closes an open record; these bytes are still accepted like any other byte.
`default_nettype none

module fastq_record_parser
    import fqp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_field_tag,
    output logic [7:0]      o_field_byte
);

    // phase tracker state
    logic [1:0] r_phase,   n_phase;
    logic       r_after_nl, n_after_nl;
    logic       r_rec_open, n_rec_open;

    // output register and skid stage
    t_result    r_out,  r_skid;
    logic       r_out_vld, r_skid_vld;

    logic       acc, take;
    logic       res_vld;
    t_result    res;

    assign o_ready = ~r_skid_vld;
    assign acc     = i_valid & o_ready;
    assign take    = r_out_vld & i_ready;

    // per-byte decision and next state
    always_comb begin
        n_phase    = r_phase;
        n_after_nl = r_after_nl;
        n_rec_open = r_rec_open;
        res_vld    = 1'b0;
        res.tag    = {1'b0, r_phase};
        res.fbyte  = i_data_byte;
        priority if (i_kind == KIND_EOI) begin
            res_vld    = 1'b1;
            res.tag    = TAG_END;
            res.fbyte  = 8'd0;
            n_phase    = PH_NAME;
            n_after_nl = 1'b1;
            n_rec_open = 1'b0;
        end else if (i_data_byte == CH_NL) begin
            n_phase    = r_phase + 2'd1;
            n_after_nl = 1'b1;
        end else if (r_phase == PH_NAME && i_data_byte == CH_AT && r_after_nl) begin
            // record start: close the previous record if one is open
            res_vld    = r_rec_open;
            res.tag    = TAG_END;
            res.fbyte  = 8'd0;
            n_rec_open = 1'b1;
            n_after_nl = 1'b0;
        end else if (r_phase == PH_COMMENT && i_data_byte == CH_PLUS && r_after_nl) begin
            // plus marker is dropped
            n_after_nl = 1'b0;
        end else begin
            res_vld    = 1'b1;
            n_after_nl = 1'b0;
        end
    end

    // state update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NAME;
            r_after_nl <= 1'b1;
            r_rec_open <= 1'b0;
        end else if (acc) begin
            r_phase    <= n_phase;
            r_after_nl <= n_after_nl;
            r_rec_open <= n_rec_open;
        end
    end

    // output register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else if (acc && res_vld) begin
                    r_out      <= res;
                end else begin
                    r_out_vld  <= 1'b0;
                end
            end else if (acc && res_vld) begin
                if (r_out_vld) begin
                    r_skid     <= res;
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out      <= res;
                    r_out_vld  <= 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_field_tag  = r_out.tag;
    assign o_field_byte = r_out.fbyte;

    // skid stage only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage holds a beat while output register is empty");

    // end of input restores the reset state of the phase tracker
    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_EOI) |=>
            (r_phase == PH_NAME && r_after_nl && !r_rec_open))
        else $error("end of input did not reset phase tracker");

    // newline advances the phase by one
    a_nl_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_DATA && i_data_byte == CH_NL) |=>
            (r_phase == 2'($past(r_phase) + 2'd1) && r_after_nl))
        else $error("newline did not advance line phase");

    // an end of input into an empty output stage shows a record end next cycle
    a_eoi_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_kind == KIND_EOI && !r_out_vld) |=>
            (r_out_vld && r_out.tag == TAG_END && r_out.fbyte == 8'd0))
        else $error("end of input did not produce a record end beat");

endmodule

`default_nettype wire
